FILE: design/rvq_pkg.sv
// ----------------------------------------------------------------------------
// rvq_pkg
// Shared widths, constants, types and helpers of the rotation vector to
// quaternion converter.
// ----------------------------------------------------------------------------
package rvq_pkg;

    // Fixed-point formats
    localparam int FRAC_BITS        = 16;
    localparam int IN_W             = 20;
    localparam int OUT_W            = 18;
    localparam int SH               = 30 - FRAC_BITS;
    localparam int CORDIC_STEPS_DEF = 18;

    // Internal widths
    localparam int SQ_W    = 2 * IN_W - 1;
    localparam int SUMSQ_W = 2 * IN_W;
    localparam int ROOT_W  = SUMSQ_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int THETA_W = ROOT_W + 1;
    localparam int DEN_W   = THETA_W + SH;
    localparam int ANG_W   = 36;
    localparam int CX_W    = 33;
    localparam int MAG_W   = IN_W + CX_W - 1;
    localparam int NUM_W   = MAG_W + 2;
    localparam int D_W     = DEN_W + 1;
    localparam int QB      = 20;
    localparam int SAT_W   = 36;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Q2.30 angle constants
    localparam logic signed [ANG_W-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [CX_W-1:0]  Q30_INV_GAIN = 33'sd652032874;

    typedef logic signed [IN_W-1:0]  t_rot;
    typedef logic signed [OUT_W-1:0] t_quat;

    localparam t_quat Q_ONE = t_quat'(1 << FRAC_BITS);

    // One classified vector as it waits for the back end
    typedef struct packed {
        logic               zero;
        t_rot [2:0]         rot;
        logic [SUMSQ_W-1:0] sumsq;
    } t_item;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Q30 arctangent of 2^-i
    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd843314857;
            5'd1:  v = 32'd497837829;
            5'd2:  v = 32'd263043836;
            5'd3:  v = 32'd133525158;
            5'd4:  v = 32'd67021686;
            5'd5:  v = 32'd33543515;
            5'd6:  v = 32'd16775850;
            5'd7:  v = 32'd8388437;
            5'd8:  v = 32'd4194282;
            5'd9:  v = 32'd2097149;
            5'd10: v = 32'd1048575;
            5'd11: v = 32'd524287;
            5'd12: v = 32'd262143;
            5'd13: v = 32'd131071;
            5'd14: v = 32'd65535;
            5'd15: v = 32'd32767;
            5'd16: v = 32'd16383;
            5'd17: v = 32'd8191;
            5'd18: v = 32'd4095;
            5'd19: v = 32'd2047;
            5'd20: v = 32'd1023;
            5'd21: v = 32'd511;
            5'd22: v = 32'd255;
            5'd23: v = 32'd127;
            5'd24: v = 32'd63;
            5'd25: v = 32'd31;
            5'd26: v = 32'd15;
            5'd27: v = 32'd8;
            5'd28: v = 32'd4;
            5'd29: v = 32'd2;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Clamp to [-1, 1] in output format
    function automatic t_quat sat_out(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] lim;
        lim = SAT_W'(1 << FRAC_BITS);
        if (v > lim) begin
            return Q_ONE;
        end else if (v < -lim) begin
            return -Q_ONE;
        end
        return v[OUT_W-1:0];
    endfunction

endpackage

FILE: design/rvq_front.sv
// ----------------------------------------------------------------------------
// rvq_front
// Accepts rotation vectors, squares the components, sums them and flags the
// zero vector.
// ----------------------------------------------------------------------------
module rvq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  rvq_pkg::t_rot i_rot_x,
    input  rvq_pkg::t_rot i_rot_y,
    input  rvq_pkg::t_rot i_rot_z,
    output logic          o_push,
    output rvq_pkg::t_item o_item
);
    import rvq_pkg::*;

    logic            r_a_vld;
    t_rot [2:0]      r_a_rot;
    logic            r_b_vld;
    t_rot [2:0]      r_b_rot;
    logic [SQ_W-1:0] r_b_sq [3];

    // Input capture
    always_ff @(posedge i_clk) begin
        r_a_rot <= {i_rot_z, i_rot_y, i_rot_x};
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_accept;
        end
    end

    // Squares, operands sign-extended to the full product width
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_b_sq[k] <= SQ_W'(SUMSQ_W'(r_a_rot[k]) * SUMSQ_W'(r_a_rot[k]));
        end
        r_b_rot <= r_a_rot;
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    // Sum of squares and zero classification
    assign o_push       = r_b_vld;
    assign o_item.rot   = r_b_rot;
    assign o_item.zero  = (r_b_rot == '0);
    assign o_item.sumsq = SUMSQ_W'(r_b_sq[0]) + SUMSQ_W'(r_b_sq[1]) + SUMSQ_W'(r_b_sq[2]);

endmodule

FILE: design/rvq_queue.sv
// ----------------------------------------------------------------------------
// rvq_queue
// Small FIFO between the front end and the computation pipeline.
// ----------------------------------------------------------------------------
module rvq_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rvq_pkg::t_item  i_item,
    input  logic            i_pop,
    output rvq_pkg::t_item  o_item,
    output rvq_pkg::t_qstat o_stat
);
    import rvq_pkg::*;

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_stat.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_item       = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
        end
    end

endmodule

FILE: design/rvq_back.sv
// ----------------------------------------------------------------------------
// rvq_back
// Pipelined square root, angle reduction, CORDIC and division that turn one
// queued vector into one quaternion per cycle.
// ----------------------------------------------------------------------------
module rvq_back #(
    parameter int STEPS = rvq_pkg::CORDIC_STEPS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  rvq_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_valid,
    output rvq_pkg::t_quat o_quat_w,
    output rvq_pkg::t_quat o_quat_x,
    output rvq_pkg::t_quat o_quat_y,
    output rvq_pkg::t_quat o_quat_z
);
    import rvq_pkg::*;

    typedef struct packed {
        logic               vld;
        logic               zero;
        t_rot [2:0]         rot;
        logic [SUMSQ_W-1:0] n;
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
    } t_sqs;

    typedef struct packed {
        logic               vld;
        logic               zero;
        t_rot [2:0]         rot;
        logic [THETA_W-1:0] theta;
    } t_ths;

    typedef struct packed {
        logic                    vld;
        logic                    zero;
        t_rot [2:0]              rot;
        logic [DEN_W-1:0]        den;
        logic signed [ANG_W-1:0] ang;
    } t_ras;

    typedef struct packed {
        logic                    vld;
        logic                    zero;
        logic                    flip;
        t_rot [2:0]              rot;
        logic [DEN_W-1:0]        den;
        logic signed [CX_W-1:0]  cx;
        logic signed [CX_W-1:0]  cy;
        logic signed [ANG_W-1:0] z;
    } t_cs;

    typedef struct packed {
        logic                   vld;
        logic                   zero;
        t_rot [2:0]             rot;
        logic [DEN_W-1:0]       den;
        logic signed [CX_W-1:0] cx;
        logic signed [CX_W-1:0] cy;
    } t_pms;

    typedef struct packed {
        logic                    vld;
        logic                    zero;
        t_quat                   w;
        logic [2:0]              neg;
        logic [DEN_W-1:0]        den;
        logic [2:0][MAG_W-1:0]   mag;
    } t_mus;

    typedef struct packed {
        logic                  vld;
        logic                  zero;
        t_quat                 w;
        logic [2:0]            neg;
        logic [D_W-1:0]        d;
        logic [2:0][D_W-1:0]   rem;
        logic [2:0][QB-1:0]    lq;
    } t_dvs;

    t_sqs r_sq [0:ROOT_W];
    t_ths r_th;
    t_ras r_ra;
    t_cs  r_cs [0:STEPS];
    t_pms r_pm;
    t_mus r_mu;
    t_dvs r_dv [0:QB];

    // The pipeline never stalls: take the queue head whenever there is one
    assign o_pop = i_vld;

    // Load into the square root
    always_ff @(posedge i_clk) begin
        r_sq[0].zero <= i_item.zero;
        r_sq[0].rot  <= i_item.rot;
        r_sq[0].n    <= i_item.sumsq;
        r_sq[0].rem  <= '0;
        r_sq[0].root <= '0;
        if (!i_rst_n) begin
            r_sq[0].vld <= 1'b0;
        end else begin
            r_sq[0].vld <= i_vld;
        end
    end

    // Square root, one result bit per stage
    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        logic [REM_W+1:0] remt;
        logic [REM_W+1:0] trial;
        logic             take;

        assign remt  = {r_sq[j].rem, r_sq[j].n[SUMSQ_W-1 -: 2]};
        assign trial = {{(REM_W-ROOT_W){1'b0}}, r_sq[j].root, 2'b01};
        assign take  = (remt >= trial);

        always_ff @(posedge i_clk) begin
            r_sq[j+1].zero <= r_sq[j].zero;
            r_sq[j+1].rot  <= r_sq[j].rot;
            r_sq[j+1].n    <= {r_sq[j].n[SUMSQ_W-3:0], 2'b00};
            r_sq[j+1].rem  <= take ? REM_W'(remt - trial) : REM_W'(remt);
            r_sq[j+1].root <= {r_sq[j].root[ROOT_W-2:0], take};
            if (!i_rst_n) begin
                r_sq[j+1].vld <= 1'b0;
            end else begin
                r_sq[j+1].vld <= r_sq[j].vld;
            end
        end
    end

    // Round the root to nearest
    always_ff @(posedge i_clk) begin
        r_th.zero  <= r_sq[ROOT_W].zero;
        r_th.rot   <= r_sq[ROOT_W].rot;
        r_th.theta <= THETA_W'(r_sq[ROOT_W].root)
                    + THETA_W'(r_sq[ROOT_W].rem > REM_W'(r_sq[ROOT_W].root));
        if (!i_rst_n) begin
            r_th.vld <= 1'b0;
        end else begin
            r_th.vld <= r_sq[ROOT_W].vld;
        end
    end

    // Half angle in Q2.30, reduced by one whole turn when at or past pi
    logic signed [ANG_W-1:0] half;
    assign half = ANG_W'({r_th.theta, {(SH-1){1'b0}}});

    always_ff @(posedge i_clk) begin
        r_ra.zero <= r_th.zero;
        r_ra.rot  <= r_th.rot;
        r_ra.den  <= DEN_W'({r_th.theta, {SH{1'b0}}});
        r_ra.ang  <= (half >= Q30_PI) ? half - Q30_TWO_PI : half;
        if (!i_rst_n) begin
            r_ra.vld <= 1'b0;
        end else begin
            r_ra.vld <= r_th.vld;
        end
    end

    // Fold into [-pi/2, pi/2] with a half turn and seed the CORDIC
    always_ff @(posedge i_clk) begin
        r_cs[0].zero <= r_ra.zero;
        r_cs[0].rot  <= r_ra.rot;
        r_cs[0].den  <= r_ra.den;
        r_cs[0].cx   <= Q30_INV_GAIN;
        r_cs[0].cy   <= '0;
        if (r_ra.ang > Q30_HALF_PI) begin
            r_cs[0].z    <= r_ra.ang - Q30_PI;
            r_cs[0].flip <= 1'b1;
        end else if (r_ra.ang < -Q30_HALF_PI) begin
            r_cs[0].z    <= r_ra.ang + Q30_PI;
            r_cs[0].flip <= 1'b1;
        end else begin
            r_cs[0].z    <= r_ra.ang;
            r_cs[0].flip <= 1'b0;
        end
        if (!i_rst_n) begin
            r_cs[0].vld <= 1'b0;
        end else begin
            r_cs[0].vld <= r_ra.vld;
        end
    end

    // CORDIC rotation, one micro-rotation per stage
    for (genvar i = 0; i < STEPS; i++) begin : g_cordic
        logic signed [CX_W-1:0]  dx;
        logic signed [CX_W-1:0]  dy;
        logic signed [ANG_W-1:0] da;

        assign dx = r_cs[i].cy >>> i;
        assign dy = r_cs[i].cx >>> i;
        assign da = ANG_W'(atan_q30(5'(i)));

        always_ff @(posedge i_clk) begin
            r_cs[i+1].zero <= r_cs[i].zero;
            r_cs[i+1].flip <= r_cs[i].flip;
            r_cs[i+1].rot  <= r_cs[i].rot;
            r_cs[i+1].den  <= r_cs[i].den;
            if (r_cs[i].z >= 0) begin
                r_cs[i+1].cx <= r_cs[i].cx - dx;
                r_cs[i+1].cy <= r_cs[i].cy + dy;
                r_cs[i+1].z  <= r_cs[i].z - da;
            end else begin
                r_cs[i+1].cx <= r_cs[i].cx + dx;
                r_cs[i+1].cy <= r_cs[i].cy - dy;
                r_cs[i+1].z  <= r_cs[i].z + da;
            end
            if (!i_rst_n) begin
                r_cs[i+1].vld <= 1'b0;
            end else begin
                r_cs[i+1].vld <= r_cs[i].vld;
            end
        end
    end

    // Undo the half turn
    always_ff @(posedge i_clk) begin
        r_pm.zero <= r_cs[STEPS].zero;
        r_pm.rot  <= r_cs[STEPS].rot;
        r_pm.den  <= r_cs[STEPS].den;
        r_pm.cx   <= r_cs[STEPS].flip ? -r_cs[STEPS].cx : r_cs[STEPS].cx;
        r_pm.cy   <= r_cs[STEPS].flip ? -r_cs[STEPS].cy : r_cs[STEPS].cy;
        if (!i_rst_n) begin
            r_pm.vld <= 1'b0;
        end else begin
            r_pm.vld <= r_cs[STEPS].vld;
        end
    end

    // Cosine to output format; products of the components with the sine
    logic signed [CX_W-1:0]      w_rnd;
    logic signed [IN_W+CX_W-1:0] num [3];

    assign w_rnd = (r_pm.cx + CX_W'(1 << (SH - 1))) >>> SH;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            num[k] = $signed(r_pm.rot[k]) * r_pm.cy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mu.zero <= r_pm.zero;
        r_mu.den  <= r_pm.den;
        r_mu.w    <= sat_out(SAT_W'(w_rnd));
        for (int k = 0; k < 3; k++) begin
            r_mu.neg[k] <= num[k][IN_W+CX_W-1];
            r_mu.mag[k] <= num[k][IN_W+CX_W-1] ? MAG_W'(-num[k]) : MAG_W'(num[k]);
        end
        if (!i_rst_n) begin
            r_mu.vld <= 1'b0;
        end else begin
            r_mu.vld <= r_pm.vld;
        end
    end

    // Numerator 2|p| + den over divisor 2 den, seeded into the divider
    logic [NUM_W-1:0] numer [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            numer[k] = {r_mu.mag[k], 1'b0} + NUM_W'(r_mu.den);
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv[0].zero <= r_mu.zero;
        r_dv[0].w    <= r_mu.w;
        r_dv[0].neg  <= r_mu.neg;
        r_dv[0].d    <= {r_mu.den, 1'b0};
        for (int k = 0; k < 3; k++) begin
            r_dv[0].rem[k] <= D_W'(numer[k][NUM_W-1:QB]);
            r_dv[0].lq[k]  <= numer[k][QB-1:0];
        end
        if (!i_rst_n) begin
            r_dv[0].vld <= 1'b0;
        end else begin
            r_dv[0].vld <= r_mu.vld;
        end
    end

    // Restoring division, one quotient bit per stage for all three lanes
    for (genvar s = 0; s < QB; s++) begin : g_div
        logic [D_W:0] remt [3];
        logic [2:0]   ge;

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                remt[k] = {r_dv[s].rem[k], r_dv[s].lq[k][QB-1]};
                ge[k]   = (remt[k] >= {1'b0, r_dv[s].d});
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv[s+1].zero <= r_dv[s].zero;
            r_dv[s+1].w    <= r_dv[s].w;
            r_dv[s+1].neg  <= r_dv[s].neg;
            r_dv[s+1].d    <= r_dv[s].d;
            for (int k = 0; k < 3; k++) begin
                r_dv[s+1].rem[k] <= ge[k] ? D_W'(remt[k] - {1'b0, r_dv[s].d})
                                          : remt[k][D_W-1:0];
                r_dv[s+1].lq[k]  <= {r_dv[s].lq[k][QB-2:0], ge[k]};
            end
            if (!i_rst_n) begin
                r_dv[s+1].vld <= 1'b0;
            end else begin
                r_dv[s+1].vld <= r_dv[s].vld;
            end
        end
    end

    // Sign, clamp and the identity for the zero vector
    logic signed [SAT_W-1:0] qv [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            qv[k] = SAT_W'(r_dv[QB].lq[k]);
            if (r_dv[QB].neg[k]) begin
                qv[k] = -qv[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_dv[QB].zero) begin
            o_quat_w <= Q_ONE;
            o_quat_x <= '0;
            o_quat_y <= '0;
            o_quat_z <= '0;
        end else begin
            o_quat_w <= r_dv[QB].w;
            o_quat_x <= sat_out(qv[0]);
            o_quat_y <= sat_out(qv[1]);
            o_quat_z <= sat_out(qv[2]);
        end
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_dv[QB].vld;
        end
    end

endmodule

FILE: design/rotation_vector_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_vector_to_quaternion
// Converts a Q3.16 rotation vector into a Q1.16 unit quaternion.
// ----------------------------------------------------------------------------
//  channel   ports                               direction  transfer
//  command   start, busy, i_rot_x/y/z            in         start && !busy
//  result    o_valid, o_quat_w/x/y/z             out        o_valid, one cycle
//
//  One vector per cycle; each result is strobed after its transfer edge, once it
//  has passed the front end and queue, the 20-stage square root, the CORDIC
//  stages and the 20-stage divider in series.
//  Synchronous active-low reset empties the pipeline and the queue.
//  The receiver cannot stall; the queue drains every cycle so busy stays low.
// ----------------------------------------------------------------------------
module rotation_vector_to_quaternion #(
    parameter int CORDIC_STEPS = rvq_pkg::CORDIC_STEPS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  rvq_pkg::t_rot  i_rot_x,
    input  rvq_pkg::t_rot  i_rot_y,
    input  rvq_pkg::t_rot  i_rot_z,
    output logic           o_valid,
    output rvq_pkg::t_quat o_quat_w,
    output rvq_pkg::t_quat o_quat_x,
    output rvq_pkg::t_quat o_quat_y,
    output rvq_pkg::t_quat o_quat_z
);
    import rvq_pkg::*;

    logic   f_push;
    t_item  f_item;
    t_item  q_item;
    t_qstat q_stat;
    logic   b_pop;

    assign busy = q_stat.full;

    // Front end: capture, square and classify
    rvq_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (start && !busy),
        .i_rot_x  (i_rot_x),
        .i_rot_y  (i_rot_y),
        .i_rot_z  (i_rot_z),
        .o_push   (f_push),
        .o_item   (f_item)
    );

    // Decoupling queue
    rvq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .i_pop   (b_pop),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    // Back end: root, CORDIC, division
    rvq_back #(
        .STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (!q_stat.empty),
        .i_item   (q_item),
        .o_pop    (b_pop),
        .o_valid  (o_valid),
        .o_quat_w (o_quat_w),
        .o_quat_x (o_quat_x),
        .o_quat_y (o_quat_y),
        .o_quat_z (o_quat_z)
    );

`ifndef SYNTHESIS
    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_stat.full)
        else $error("decoupling queue filled");

    a_w_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_quat_w <= Q_ONE) && (o_quat_w >= -Q_ONE))
        else $error("quaternion w out of range");

    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_quat_x <= Q_ONE) && (o_quat_x >= -Q_ONE))
        else $error("quaternion x out of range");
`endif

endmodule
